// ===== rtl/dual_chip_lcd_frame_sequencer_defines.svh =====
// Assertion macros for the LCD frame sequencer.
// No dependencies; included by the top level only.
`ifndef DUAL_CHIP_LCD_FRAME_SEQUENCER_DEFINES_SVH
`define DUAL_CHIP_LCD_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcdseq_pkg.sv =====
// Shared types, command bytes and write decode for the LCD frame sequencer.
// No dependencies.
package lcdseq_pkg;

  // Input and result beats
  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic       left_chip;
    logic [7:0] bus_byte;
    logic       last_of_run;
  } out_item_t;

  // Operation codes
  localparam logic OP_INIT  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ONLY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCAN_INV = 2'd1;

  // Controller command bytes
  localparam logic [7:0] CMD_RESET      = 8'hE2;
  localparam logic [7:0] CMD_PAGE       = 8'hB8;
  localparam logic [7:0] CMD_COL_LEFT   = 8'h13;
  localparam logic [7:0] CMD_COL_RIGHT  = 8'h00;
  localparam logic [7:0] CMD_RMW_END    = 8'hEE;
  localparam logic [7:0] CMD_STATIC_OFF = 8'hA4;
  localparam logic [7:0] CMD_DUTY_32    = 8'hA9;
  localparam logic [7:0] CMD_START_LINE = 8'hC0;
  localparam logic [7:0] CMD_ADC_REV    = 8'hA1;
  localparam logic [7:0] CMD_ADC_NORM   = 8'hA0;
  localparam logic [7:0] CMD_DISP_ON    = 8'hAF;

  // Power-up sequence length
  localparam int unsigned INIT_LEN = 14;
  localparam int unsigned INIT_CNT_W = $clog2(INIT_LEN);

  // Page number bits carried into the page select command
  localparam int unsigned JOB_PAGE_W = 3;

  // Command/data steps of a frame job, issued lowest index first
  localparam int unsigned STEP_N     = 7;
  localparam int unsigned STEP_IDX_W = 3;
  localparam logic [STEP_IDX_W-1:0] STEP_RST_L = 3'd0;
  localparam logic [STEP_IDX_W-1:0] STEP_RST_R = 3'd1;
  localparam logic [STEP_IDX_W-1:0] STEP_SEL_L = 3'd2;
  localparam logic [STEP_IDX_W-1:0] STEP_COL_L = 3'd3;
  localparam logic [STEP_IDX_W-1:0] STEP_SEL_R = 3'd4;
  localparam logic [STEP_IDX_W-1:0] STEP_COL_R = 3'd5;
  localparam logic [STEP_IDX_W-1:0] STEP_DATA  = 3'd6;

  // Job handed from the classifier to the write sequencer
  typedef struct packed {
    logic                  init;
    logic                  rsi;
    logic [STEP_N-1:0]     steps;
    logic                  data_left;
    logic [JOB_PAGE_W-1:0] page;
    logic [7:0]            pixel;
  } job_t;

  // Job queue
  localparam int unsigned JOBQ_DEPTH = 4;
  localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  // One write of the power-up sequence; even entries go to the left chip
  function automatic out_item_t init_write(logic [INIT_CNT_W-1:0] idx, logic rsi);
    out_item_t w;
    w.is_data     = 1'b0;
    w.left_chip   = ~idx[0];
    w.last_of_run = 1'b0;
    case (idx[INIT_CNT_W-1:1])
      3'd0:    w.bus_byte = CMD_RESET;
      3'd1:    w.bus_byte = CMD_RMW_END;
      3'd2:    w.bus_byte = CMD_STATIC_OFF;
      3'd3:    w.bus_byte = CMD_DUTY_32;
      3'd4:    w.bus_byte = CMD_START_LINE;
      3'd5:    w.bus_byte = (idx[0] && !rsi) ? CMD_ADC_NORM : CMD_ADC_REV;
      3'd6:    w.bus_byte = CMD_DISP_ON;
      default: w.bus_byte = CMD_DISP_ON;
    endcase
    return w;
  endfunction

  // One write of a frame job
  function automatic out_item_t step_write(logic [STEP_IDX_W-1:0] idx, job_t job);
    out_item_t w;
    logic [7:0] page_cmd;
    page_cmd      = CMD_PAGE | 8'(job.page);
    w.last_of_run = 1'b0;
    case (idx)
      STEP_RST_L: begin
        w.is_data = 1'b0; w.left_chip = 1'b1; w.bus_byte = CMD_RESET;
      end
      STEP_RST_R: begin
        w.is_data = 1'b0; w.left_chip = 1'b0; w.bus_byte = CMD_RESET;
      end
      STEP_SEL_L: begin
        w.is_data = 1'b0; w.left_chip = 1'b1; w.bus_byte = page_cmd;
      end
      STEP_COL_L: begin
        w.is_data = 1'b0; w.left_chip = 1'b1; w.bus_byte = CMD_COL_LEFT;
      end
      STEP_SEL_R: begin
        w.is_data = 1'b0; w.left_chip = 1'b0; w.bus_byte = page_cmd;
      end
      STEP_COL_R: begin
        w.is_data = 1'b0; w.left_chip = 1'b0; w.bus_byte = CMD_COL_RIGHT;
      end
      default: begin
        w.is_data = 1'b1; w.left_chip = job.data_left; w.bus_byte = job.pixel;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dual_chip_lcd_frame_sequencer.sv =====
// Top level of the two-chip LCD frame sequencer.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_jobq, lcdseq_back and the defines header.
//
//   channel  ports                               beat
//   in       in_push / in_full, in_item          operation, pixel_byte
//   out      out_pop / out_empty, out_item       is_data, left_chip, bus_byte, last_of_run
//   cfg      cfg_valid / cfg_ready, cfg_index    cfg_wdata (always ready)
//
// Each input beat is classified in the cycle it is taken and queued as a job
// (four entries). The sequencer issues one bus write per cycle while the output
// slot is free: a plain data byte makes one write, a row start or the right half
// three, the frame start five (four at every row start in left-only mode), an init
// fourteen. A swallowed byte costs nothing downstream. Each head-job write is
// registered. Synchronous reset clears position, config, queue pointers and the
// output valid flag; a stalled out_pop backs up through the queue to in_full.
`include "dual_chip_lcd_frame_sequencer_defines.svh"

module dual_chip_lcd_frame_sequencer #(
  parameter int unsigned PAGE_COUNT   = 4,
  parameter int unsigned ROW_COLUMNS  = 122,
  parameter int unsigned HALF_COLUMNS = 61
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  lcdseq_pkg::in_item_t             in_item,
  input  logic                             out_pop,
  output logic                             out_empty,
  output lcdseq_pkg::out_item_t            out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                             cfg_wdata
);

  logic                   accept;
  logic                   q_push, q_pop;
  lcdseq_pkg::job_t       q_job, q_head;
  lcdseq_pkg::jobq_stat_t q_stat;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push & ~q_stat.full;

  lcdseq_front #(
    .PAGE_COUNT   (PAGE_COUNT),
    .ROW_COLUMNS  (ROW_COLUMNS),
    .HALF_COLUMNS (HALF_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  lcdseq_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // Checks
  `LCDSEQ_ASSERT_NOW(a_jobq_no_overflow, q_push, !q_stat.full, "job pushed into full queue")
  `LCDSEQ_ASSERT_NOW(a_jobq_no_underflow, q_pop, !q_stat.empty, "job popped from empty queue")
  `LCDSEQ_ASSERT_NEXT(a_pop_marks_last, q_pop, !out_empty && out_item.last_of_run,
                      "job retired without a last write")

endmodule

// ===== rtl/lcdseq_front.sv =====
// Front end: config registers, page/column tracking and job classification.
// Depends on lcdseq_pkg.
module lcdseq_front #(
  parameter int unsigned PAGE_COUNT   = 4,
  parameter int unsigned ROW_COLUMNS  = 122,
  parameter int unsigned HALF_COLUMNS = 61
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  lcdseq_pkg::in_item_t              in_item,
  input  logic                              cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                              cfg_wdata,
  output logic                              q_push,
  output lcdseq_pkg::job_t                  q_job
);

  localparam int unsigned COL_W  = $clog2(ROW_COLUMNS);
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(ROW_COLUMNS - 1);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [7:0]        HALF_COL  = 8'(HALF_COLUMNS);

  logic              left_only_r, left_only_nxt;
  logic              rsi_r, rsi_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              col0, page0, at_half, below_half;

  // Config writes
  always_comb begin
    left_only_nxt = left_only_r;
    rsi_nxt       = rsi_r;
    if (cfg_we) begin
      case (cfg_index)
        lcdseq_pkg::CFG_LEFT_ONLY:      left_only_nxt = cfg_wdata;
        lcdseq_pkg::CFG_RIGHT_SCAN_INV: rsi_nxt       = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position decode
  assign col0       = (col_r == '0);
  assign page0      = (page_r == '0);
  assign at_half    = (8'(col_r) == HALF_COL);
  assign below_half = (8'(col_r) < HALF_COL);

  // Classify the beat into a job
  always_comb begin
    q_job       = '0;
    q_job.rsi   = rsi_r;
    q_job.page  = lcdseq_pkg::JOB_PAGE_W'(page_r);
    q_job.pixel = in_item.pixel_byte;
    if (in_item.operation == lcdseq_pkg::OP_INIT) begin
      q_job.init = 1'b1;
    end else if (left_only_r) begin
      q_job.data_left                      = 1'b1;
      q_job.steps[lcdseq_pkg::STEP_RST_L]  = col0;
      q_job.steps[lcdseq_pkg::STEP_SEL_L]  = col0;
      q_job.steps[lcdseq_pkg::STEP_COL_L]  = col0;
      q_job.steps[lcdseq_pkg::STEP_DATA]   = below_half;
    end else begin
      q_job.data_left                      = below_half;
      q_job.steps[lcdseq_pkg::STEP_RST_L]  = col0 & page0;
      q_job.steps[lcdseq_pkg::STEP_RST_R]  = col0 & page0;
      q_job.steps[lcdseq_pkg::STEP_SEL_L]  = col0;
      q_job.steps[lcdseq_pkg::STEP_COL_L]  = col0;
      q_job.steps[lcdseq_pkg::STEP_SEL_R]  = at_half;
      q_job.steps[lcdseq_pkg::STEP_COL_R]  = at_half;
      q_job.steps[lcdseq_pkg::STEP_DATA]   = 1'b1;
    end
  end

  // Swallowed bytes make no job
  assign q_push = accept & (q_job.init | (|q_job.steps));

  // Position advance: column wraps into the next page, an init rewinds to zero
  always_comb begin
    col_nxt  = col_r;
    page_nxt = page_r;
    if (accept) begin
      if (in_item.operation == lcdseq_pkg::OP_INIT) begin
        col_nxt  = '0;
        page_nxt = '0;
      end else if (col_r == COL_LAST) begin
        col_nxt  = '0;
        page_nxt = (page_r == PAGE_LAST) ? '0 : page_r + PAGE_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_only_r <= 1'b0;
      rsi_r       <= 1'b0;
      col_r       <= '0;
      page_r      <= '0;
    end else begin
      left_only_r <= left_only_nxt;
      rsi_r       <= rsi_nxt;
      col_r       <= col_nxt;
      page_r      <= page_nxt;
    end
  end

endmodule

// ===== rtl/lcdseq_jobq.sv =====
// Short job queue between the classifier and the write sequencer.
// Depends on lcdseq_pkg.
module lcdseq_jobq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lcdseq_pkg::job_t       push_job,
  input  logic                   pop,
  output lcdseq_pkg::job_t       head,
  output lcdseq_pkg::jobq_stat_t stat
);

  localparam int unsigned CNT_W = lcdseq_pkg::JOBQ_PTR_W + 1;

  lcdseq_pkg::job_t                     slot_r [lcdseq_pkg::JOBQ_DEPTH];
  logic [lcdseq_pkg::JOBQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lcdseq_pkg::JOBQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                     cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(lcdseq_pkg::JOBQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + lcdseq_pkg::JOBQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + lcdseq_pkg::JOBQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/lcdseq_back.sv =====
// Back end: walks the head job one bus write a cycle into a free output register.
// Depends on lcdseq_pkg.
module lcdseq_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdseq_pkg::job_t       head,
  input  lcdseq_pkg::jobq_stat_t q_stat,
  output logic                   q_pop,
  input  logic                   out_pop,
  output logic                   out_empty,
  output lcdseq_pkg::out_item_t  out_item
);

  localparam logic [lcdseq_pkg::INIT_CNT_W-1:0] INIT_LAST =
    lcdseq_pkg::INIT_CNT_W'(lcdseq_pkg::INIT_LEN - 1);

  logic                                  out_valid_r, out_valid_nxt;
  lcdseq_pkg::out_item_t                 out_r;
  logic                                  fresh_r, fresh_nxt;
  logic [lcdseq_pkg::STEP_N-1:0]         rem_r, rem_nxt;
  logic [lcdseq_pkg::INIT_CNT_W-1:0]     icnt_r, icnt_nxt;
  logic [lcdseq_pkg::STEP_N-1:0]         cur_steps, rem_after;
  logic [lcdseq_pkg::STEP_IDX_W-1:0]     step_idx;
  logic                                  advance, emit, last;
  lcdseq_pkg::out_item_t                 wr;

  // Output slot frees when empty or being taken
  assign advance = ~out_valid_r | out_pop;
  assign emit    = advance & ~q_stat.empty;

  // Lowest pending step of the head job
  assign cur_steps = fresh_r ? head.steps : rem_r;
  always_comb begin
    step_idx = lcdseq_pkg::STEP_DATA;
    for (int i = lcdseq_pkg::STEP_N - 1; i >= 0; i--) begin
      if (cur_steps[i]) step_idx = lcdseq_pkg::STEP_IDX_W'(i);
    end
  end
  assign rem_after = cur_steps & ~(lcdseq_pkg::STEP_N'(1) << step_idx);

  // Write for this cycle
  always_comb begin
    if (head.init) begin
      wr   = lcdseq_pkg::init_write(icnt_r, head.rsi);
      last = (icnt_r == INIT_LAST);
    end else begin
      wr   = lcdseq_pkg::step_write(step_idx, head);
      last = (rem_after == '0);
    end
    wr.last_of_run = last;
  end

  assign q_pop = emit & last;

  // Sequencer state
  always_comb begin
    fresh_nxt     = fresh_r;
    rem_nxt       = rem_r;
    icnt_nxt      = icnt_r;
    out_valid_nxt = out_valid_r & ~out_pop;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (last) begin
        fresh_nxt = 1'b1;
        icnt_nxt  = '0;
      end else begin
        fresh_nxt = 1'b0;
        rem_nxt   = rem_after;
        icnt_nxt  = icnt_r + lcdseq_pkg::INIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b1;
      icnt_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      fresh_r     <= fresh_nxt;
      icnt_r      <= icnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= wr;
    end
    if (emit & ~last) begin
      rem_r <= rem_nxt;
    end
  end

  assign out_empty = ~out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== verif/dual_chip_lcd_frame_sequencer_chk.sv =====
`timescale 1ns / 100ps
// Scoreboard for the LCD frame sequencer: watches the input, result and register
// channels, predicts every bus write and compares it with what the block issues.
// Depends on lcdseq_pkg.
module dual_chip_lcd_frame_sequencer_chk #(
  parameter int unsigned PAGE_COUNT   = 4,
  parameter int unsigned ROW_COLUMNS  = 122,
  parameter int unsigned HALF_COLUMNS = 61
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_full,
  input  lcdseq_pkg::in_item_t             in_item,
  input  logic                             out_pop,
  input  logic                             out_empty,
  input  lcdseq_pkg::out_item_t            out_item,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                             cfg_wdata,
  output int                               fail_count,
  output int                               pending_writes,
  output int                               writes_checked,
  output int                               productive_beats
);

  localparam int unsigned MAX_BURST        = lcdseq_pkg::INIT_LEN;
  localparam int unsigned ADC_PAIR         = 5;
  localparam int          SHOWN_MISMATCHES = 10;

  // Mirror of the block's position and registers
  logic [2:0] page_pos;
  logic [6:0] col_pos;
  logic       left_only_q;
  logic       scan_inv_q;

  lcdseq_pkg::out_item_t expected_writes[$];
  lcdseq_pkg::out_item_t want;

  function automatic lcdseq_pkg::out_item_t bus_write(logic data, logic left,
                                                      logic [7:0] value);
    lcdseq_pkg::out_item_t w;
    w.is_data     = data;
    w.left_chip   = left;
    w.bus_byte    = value;
    w.last_of_run = 1'b0;
    return w;
  endfunction

  // Column advance with wrap into the next page, pages wrap to zero
  function automatic void step_position();
    if (int'(col_pos) + 1 >= int'(ROW_COLUMNS)) begin
      col_pos  = 7'd0;
      page_pos = (int'(page_pos) + 1 >= int'(PAGE_COUNT)) ? 3'd0 : 3'(page_pos + 3'd1);
    end else begin
      col_pos = 7'(col_pos + 7'd1);
    end
  endfunction

  // Bus writes caused by one input beat, queued oldest first
  function automatic void predict_bus_writes(lcdseq_pkg::in_item_t beat);
    lcdseq_pkg::out_item_t burst [MAX_BURST];
    logic [7:0]            init_cmds [lcdseq_pkg::INIT_LEN/2];
    logic [7:0]            page_cmd;
    int unsigned           col;
    int                    n;
    init_cmds = '{lcdseq_pkg::CMD_RESET, lcdseq_pkg::CMD_RMW_END,
                  lcdseq_pkg::CMD_STATIC_OFF, lcdseq_pkg::CMD_DUTY_32,
                  lcdseq_pkg::CMD_START_LINE, lcdseq_pkg::CMD_ADC_REV,
                  lcdseq_pkg::CMD_DISP_ON};
    page_cmd  = lcdseq_pkg::CMD_PAGE | {5'd0, page_pos};
    col       = col_pos;
    n         = 0;
    if (beat.operation == lcdseq_pkg::OP_INIT) begin
      // power-up: left/right pairs, right scan direction from the register
      for (int i = 0; i < int'(lcdseq_pkg::INIT_LEN); i++) begin
        burst[n] = bus_write(1'b0, (i % 2) == 0, init_cmds[i / 2]);
        if (i / 2 == ADC_PAIR && i % 2 == 1)
          burst[n].bus_byte = scan_inv_q ? lcdseq_pkg::CMD_ADC_REV : lcdseq_pkg::CMD_ADC_NORM;
        n++;
      end
      page_pos = 3'd0;
      col_pos  = 7'd0;
    end else if (left_only_q) begin
      if (col == 0) begin
        burst[n] = bus_write(1'b0, 1'b1, lcdseq_pkg::CMD_RESET);    n++;
        burst[n] = bus_write(1'b0, 1'b1, page_cmd);                 n++;
        burst[n] = bus_write(1'b0, 1'b1, lcdseq_pkg::CMD_COL_LEFT); n++;
      end
      // right half is swallowed
      if (col < HALF_COLUMNS) begin
        burst[n] = bus_write(1'b1, 1'b1, beat.pixel_byte); n++;
      end
      step_position();
    end else begin
      if (col == 0 && page_pos == 3'd0) begin
        burst[n] = bus_write(1'b0, 1'b1, lcdseq_pkg::CMD_RESET); n++;
        burst[n] = bus_write(1'b0, 1'b0, lcdseq_pkg::CMD_RESET); n++;
      end
      if (col == 0) begin
        burst[n] = bus_write(1'b0, 1'b1, page_cmd);                 n++;
        burst[n] = bus_write(1'b0, 1'b1, lcdseq_pkg::CMD_COL_LEFT); n++;
      end
      if (col == HALF_COLUMNS) begin
        burst[n] = bus_write(1'b0, 1'b0, page_cmd);                  n++;
        burst[n] = bus_write(1'b0, 1'b0, lcdseq_pkg::CMD_COL_RIGHT); n++;
      end
      burst[n] = bus_write(1'b1, col < HALF_COLUMNS, beat.pixel_byte); n++;
      step_position();
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1)
        burst[k].last_of_run = 1'b1;
      expected_writes.push_back(burst[k]);
    end
    if (n > 0)
      productive_beats++;
  endfunction

  // Compare popped beats, predict pushed beats, then apply register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      page_pos         = 3'd0;
      col_pos          = 7'd0;
      left_only_q      = 1'b0;
      scan_inv_q       = 1'b0;
      expected_writes.delete();
      fail_count       = 0;
      writes_checked   = 0;
      productive_beats = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_writes.size() == 0) begin
          if (fail_count < SHOWN_MISMATCHES)
            $display({"ERROR: bus write %0d with nothing expected:",
                      " data=%0b left=%0b byte=%02h last=%0b"},
                     writes_checked, out_item.is_data, out_item.left_chip,
                     out_item.bus_byte, out_item.last_of_run);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          if (out_item.is_data !== want.is_data || out_item.left_chip !== want.left_chip ||
              out_item.bus_byte !== want.bus_byte ||
              out_item.last_of_run !== want.last_of_run) begin
            if (fail_count < SHOWN_MISMATCHES)
              $display({"ERROR: bus write %0d: expected data=%0b left=%0b byte=%02h last=%0b,",
                        " got data=%0b left=%0b byte=%02h last=%0b"},
                       writes_checked, want.is_data, want.left_chip, want.bus_byte,
                       want.last_of_run, out_item.is_data, out_item.left_chip,
                       out_item.bus_byte, out_item.last_of_run);
            fail_count++;
          end
        end
        writes_checked++;
      end
      if (in_push && !in_full)
        predict_bus_writes(in_item);
      if (cfg_valid && cfg_ready) begin
        // indexes outside the register list are ignored
        if (cfg_index == lcdseq_pkg::CFG_LEFT_ONLY)
          left_only_q = cfg_wdata;
        else if (cfg_index == lcdseq_pkg::CFG_RIGHT_SCAN_INV)
          scan_inv_q = cfg_wdata;
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

// ===== verif/dual_chip_lcd_frame_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the LCD frame sequencer: clock, reset, stimulus and verdict.
// Depends on lcdseq_pkg, the block and dual_chip_lcd_frame_sequencer_chk.
module dual_chip_lcd_frame_sequencer_tb;

  localparam int unsigned PAGE_COUNT   = 4;
  localparam int unsigned ROW_COLUMNS  = 122;
  localparam int unsigned HALF_COLUMNS = 61;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int PHASE_BEATS  = 91;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  // Register indexes past the end of the list
  localparam logic [lcdseq_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [lcdseq_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                             clk;
  logic                             rst_n;
  logic                             in_push;
  logic                             in_full;
  lcdseq_pkg::in_item_t             in_item;
  logic                             out_pop;
  logic                             out_empty;
  lcdseq_pkg::out_item_t            out_item;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic                             cfg_wdata;

  int   fail_count;
  int   pending_writes;
  int   writes_checked;
  int   productive_beats;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count   = 0;
  int   init_beats    = 0;
  int   frame_beats   = 0;
  int   reg_writes    = 0;
  logic hold_active;
  event hold_go;

  dual_chip_lcd_frame_sequencer #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ROW_COLUMNS (ROW_COLUMNS),
    .HALF_COLUMNS(HALF_COLUMNS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  dual_chip_lcd_frame_sequencer_chk #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ROW_COLUMNS (ROW_COLUMNS),
    .HALF_COLUMNS(HALF_COLUMNS)
  ) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_item         (in_item),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_writes  (pending_writes),
    .writes_checked  (writes_checked),
    .productive_beats(productive_beats)
  );

  // Clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: no completion after %0d cycles, %0d writes still expected",
               cycle_count, pending_writes);
      $display("simulation failed");
      $finish;
    end
  end

  // Long output stall, counted here so the sender keeps pushing meanwhile
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_go);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Result side: random pop with the current idle rate
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = rst_n && !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // One input beat; entered and left at a falling edge, push held while full
  task automatic send_beat(input logic op, input logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push            = 1'b1;
    in_item.operation  = op;
    in_item.pixel_byte = pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (op == lcdseq_pkg::OP_INIT)
      init_beats++;
    else
      frame_beats++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [lcdseq_pkg::CFG_IDX_W-1:0] idx, input logic value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every expected write has been taken, then idle before the next step
  task automatic settle();
    in_push = 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random frame bytes under one register setting, inits as rare noise
  task automatic run_phase(input logic left_only, input logic scan_inv, input int send_pct,
                           input int recv_pct, input int init_pct, input bit with_hold);
    int goal;
    set_idle(send_pct, recv_pct);
    write_reg(lcdseq_pkg::CFG_LEFT_ONLY, left_only);
    write_reg(lcdseq_pkg::CFG_RIGHT_SCAN_INV, scan_inv);
    if (with_hold)
      -> hold_go;
    goal = init_beats + frame_beats + PHASE_BEATS;
    while (init_beats + frame_beats < goal) begin
      if ($urandom_range(99) < init_pct)
        send_beat(lcdseq_pkg::OP_INIT, 8'($urandom_range(255)));
      else
        send_beat(lcdseq_pkg::OP_PIXEL, 8'($urandom_range(255)));
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = lcdseq_pkg::CFG_LEFT_ONLY;
    cfg_wdata = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    set_idle(17, 86);
    @(negedge clk);

    // Directed: both register values, out-of-list indexes, init, frame start
    write_reg(lcdseq_pkg::CFG_LEFT_ONLY, 1'b0);
    write_reg(lcdseq_pkg::CFG_RIGHT_SCAN_INV, 1'b0);
    write_reg(CFG_SPARE_2, 1'b1);
    send_beat(lcdseq_pkg::OP_INIT, 8'hFF);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h00);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'hFF);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h01);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h80);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'hAA);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h55);
    settle();
    // inverted right scan in the power-up sequence
    write_reg(lcdseq_pkg::CFG_RIGHT_SCAN_INV, 1'b1);
    send_beat(lcdseq_pkg::OP_INIT, 8'h00);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'hFF);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h00);
    settle();
    // left-only switched on in the middle of a row
    write_reg(lcdseq_pkg::CFG_LEFT_ONLY, 1'b1);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h3C);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'hC3);
    settle();
    // left-only from a rewound position: per-page left reset
    send_beat(lcdseq_pkg::OP_INIT, 8'hA5);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h81);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h7E);
    settle();
    write_reg(CFG_SPARE_3, 1'b0);
    write_reg(CFG_SPARE_2, 1'b0);
    write_reg(lcdseq_pkg::CFG_LEFT_ONLY, 1'b0);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'h0F);
    send_beat(lcdseq_pkg::OP_PIXEL, 8'hF0);
    settle();

    // Random: long runs of frame bytes reach the right half and later pages
    run_phase(1'b1, 1'b0, 17, 86, 0, 1'b0);
    run_phase(1'b0, 1'b1, 86, 17, 0, 1'b0);
    run_phase(1'b1, 1'b1, 0, 0, 0, 1'b0);
    run_phase(1'b0, 1'b0, 0, 0, 2, 1'b1);

    $display("Covered %0d input beats (%0d init, %0d frame bytes, %0d with bus writes)",
             init_beats + frame_beats, init_beats, frame_beats, productive_beats);
    $display("and %0d register writes, with %0d bus writes compared across four settings.",
             reg_writes, writes_checked);
    $display("Output was held off once for %0d cycles while input kept arriving.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("simulation ok");
    end else begin
      $display("ERROR: %0d failures, %0d writes never arrived", fail_count, pending_writes);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
